[sv/indexed_array_stack_top_macros.svh]
// Assertion macros for the indexed array stack.
// Used by ias_ctrl; needs nothing else.
`ifndef INDEXED_ARRAY_STACK_TOP_MACROS_SVH
`define INDEXED_ARRAY_STACK_TOP_MACROS_SVH

// same-cycle implication
`define IAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ias_pkg.sv]
// Shared types and constants for the indexed array stack.
// No dependencies.
package ias_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int CMD_W          = 3;
  localparam int POS_W          = 4;
  localparam int DATA_W         = 32;
  localparam int FILL_W         = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_FROM_LO = 2'd2,
    OP_FROM_HI = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic ok;
    logic rd_en;
  } ctl_t;

endpackage

[sv/ias_in_if.sv]
// Request channel into the indexed array stack.
// Depends on ias_pkg for field widths.
interface ias_in_if;
  logic                       valid;
  logic                       ready;
  logic [ias_pkg::CMD_W-1:0]  command;
  logic [ias_pkg::POS_W-1:0]  position;
  logic [ias_pkg::DATA_W-1:0] data_in;

  modport source (output valid, command, position, data_in, input ready);
  modport sink   (input valid, command, position, data_in, output ready);
endinterface

[sv/ias_out_if.sv]
// Result channel out of the indexed array stack.
// Depends on ias_pkg for field widths.
interface ias_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [ias_pkg::DATA_W-1:0] data_out;
  logic [ias_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, ok, data_out, fill_count, input ready);
  modport sink   (input valid, ok, data_out, fill_count, output ready);
endinterface

[sv/ias_cell.sv]
// One storage cell of the array: loads, takes a neighbour's value or holds.
// Depends on ias_pkg.
module ias_cell #(
  parameter int ELEM_WIDTH = ias_pkg::ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  ias_pkg::cell_op_t     op,
  input  logic [ELEM_WIDTH-1:0] din,
  input  logic [ELEM_WIDTH-1:0] lo_q,
  input  logic [ELEM_WIDTH-1:0] hi_q,
  input  logic                  sel,
  output logic [ELEM_WIDTH-1:0] q,
  output logic [ELEM_WIDTH-1:0] rd_part
);

  logic [ELEM_WIDTH-1:0] elem_r;
  logic [ELEM_WIDTH-1:0] elem_nxt;

  always_comb begin
    case (op)
      ias_pkg::OP_LOAD:    elem_nxt = din;
      ias_pkg::OP_FROM_LO: elem_nxt = lo_q;
      ias_pkg::OP_FROM_HI: elem_nxt = hi_q;
      default:             elem_nxt = elem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign q       = elem_r;
  assign rd_part = elem_r & {ELEM_WIDTH{sel}};

endmodule

[sv/ias_ctrl.sv]
// Command decode, fill count and per-cell shift control.
// Depends on ias_pkg and indexed_array_stack_top_macros.svh.
`include "indexed_array_stack_top_macros.svh"

module ias_ctrl #(
  parameter int DEPTH = ias_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [ias_pkg::CMD_W-1:0]  command,
  input  logic [ias_pkg::POS_W-1:0]  position,
  output ias_pkg::ctl_t              ctl,
  output ias_pkg::cell_op_t          ops [DEPTH],
  output logic [IW-1:0]              rd_idx,
  output logic [CW-1:0]              count_after
);

  localparam int PCW = (CW > ias_pkg::POS_W) ? CW : ias_pkg::POS_W;

  ias_pkg::cmd_t cmd_e;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic [CW-1:0]  cnt_m1;
  logic [PCW-1:0] pos_x;
  logic [PCW-1:0] cnt_x;
  logic           full;
  logic           empty;
  logic           pos_lt;
  logic           pos_le;
  logic           ok;
  logic           rd_en;
  logic           inc;
  logic           dec;
  logic [DEPTH-1:0] load_vec;

  assign cmd_e  = ias_pkg::cmd_t'(command);
  assign pos_x  = PCW'(position);
  assign cnt_x  = PCW'(count_r);
  assign cnt_m1 = count_r - CW'(1);
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign pos_lt = (pos_x < cnt_x);
  assign pos_le = (pos_x <= cnt_x);

  always_comb begin
    ok    = 1'b0;
    rd_en = 1'b0;
    inc   = 1'b0;
    dec   = 1'b0;
    unique case (cmd_e)
      ias_pkg::CMD_PUSH: begin
        ok  = !full;
        inc = !full;
      end
      ias_pkg::CMD_POP: begin
        ok    = !empty;
        rd_en = 1'b1;
        dec   = !empty;
      end
      ias_pkg::CMD_GET: begin
        ok    = pos_lt;
        rd_en = 1'b1;
      end
      ias_pkg::CMD_INSERT: begin
        ok  = !full && pos_le;
        inc = !full && pos_le;
      end
      ias_pkg::CMD_REMOVE: begin
        ok    = pos_lt;
        rd_en = 1'b1;
        dec   = pos_lt;
      end
      default: ;
    endcase
  end

  assign ctl.ok    = ok;
  assign ctl.rd_en = rd_en;
  assign rd_idx    = (cmd_e == ias_pkg::CMD_POP) ? cnt_m1[IW-1:0] : pos_x[IW-1:0];

  always_comb begin
    if (inc) begin
      count_after = count_r + CW'(1);
    end else if (dec) begin
      count_after = cnt_m1;
    end else begin
      count_after = count_r;
    end
  end

  assign count_nxt = fire ? count_after : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // push loads at the top; insert loads at position and pushes the rest up;
  // remove pulls everything from position upwards down by one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = ias_pkg::OP_HOLD;
      if (fire && ok) begin
        if (cmd_e == ias_pkg::CMD_PUSH) begin
          if (count_r == CW'(i)) ops[i] = ias_pkg::OP_LOAD;
        end else if (cmd_e == ias_pkg::CMD_INSERT) begin
          if (pos_x == PCW'(i)) begin
            ops[i] = ias_pkg::OP_LOAD;
          end else if (pos_x < PCW'(i)) begin
            ops[i] = ias_pkg::OP_FROM_LO;
          end
        end else if (cmd_e == ias_pkg::CMD_REMOVE) begin
          if (pos_x <= PCW'(i) && i != DEPTH - 1) ops[i] = ias_pkg::OP_FROM_HI;
        end
      end
      load_vec[i] = (ops[i] == ias_pkg::OP_LOAD);
    end
  end

  `IAS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "fill count above depth")
  `IAS_ASSERT_NOW(a_one_load, clk, rst_n, 1'b1, $onehot0(load_vec), "more than one cell loaded")
  `IAS_ASSERT_NEXT(a_reject_holds, clk, rst_n, fire && !ok, $stable(count_r), "rejected request moved count")
  `IAS_ASSERT_NEXT(a_grow, clk, rst_n, fire && inc, count_r == $past(count_r) + CW'(1), "count did not grow")

endmodule

[sv/indexed_array_stack_top.sv]
// Indexed array stack: a row of cells with push, pop, get, insert and remove.
// Depends on ias_pkg, ias_in_if, ias_out_if, ias_ctrl and ias_cell.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid / ready        command, position, data_in
//  out_ch    out  valid / ready        ok, data_out, fill_count
//
// One request per cycle while the output register can take it; each result
// is registered when its request is accepted. All cells shift in parallel,
// so insert and remove keep pace with the rest. Reset clears the fill count
// and the output valid; cell contents are not reset. A request is taken while
// the output register is empty or being emptied in the same cycle.
module indexed_array_stack_top #(
  parameter int DEPTH      = ias_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = ias_pkg::ELEM_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ias_in_if.sink     in_ch,
  ias_out_if.source  out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  ias_pkg::ctl_t          ctl;
  ias_pkg::cell_op_t      ops [DEPTH];
  logic [IW-1:0]          rd_idx;
  logic [CW-1:0]          count_after;
  logic                   fire;
  logic [ELEM_WIDTH-1:0]  din;
  logic [63:0]            din_w;
  logic [ELEM_WIDTH-1:0]  q       [DEPTH];
  logic [ELEM_WIDTH-1:0]  rd_part [DEPTH];
  logic [ELEM_WIDTH-1:0]  rd_word;
  logic [63:0]            rd_w;
  logic [31:0]            cnt_w;

  logic                       out_valid_r;
  logic                       ok_r;
  logic [ias_pkg::DATA_W-1:0] data_r;
  logic [ias_pkg::FILL_W-1:0] fill_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign din_w       = 64'(in_ch.data_in);
  assign din         = din_w[ELEM_WIDTH-1:0];

  ias_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .IW    (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .command     (in_ch.command),
    .position    (in_ch.position),
    .ctl         (ctl),
    .ops         (ops),
    .rd_idx      (rd_idx),
    .count_after (count_after)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] lo_q;
    logic [ELEM_WIDTH-1:0] hi_q;
    if (g == 0) begin : g_lo_edge
      assign lo_q = q[g];
    end else begin : g_lo
      assign lo_q = q[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi_edge
      assign hi_q = q[g];
    end else begin : g_hi
      assign hi_q = q[g+1];
    end
    ias_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk     (clk),
      .op      (ops[g]),
      .din     (din),
      .lo_q    (lo_q),
      .hi_q    (hi_q),
      .sel     (rd_idx == IW'(g)),
      .q       (q[g]),
      .rd_part (rd_part[g])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | rd_part[i];
    end
  end

  assign rd_w  = 64'(rd_word);
  assign cnt_w = 32'(count_after);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ok_r   <= ctl.ok;
      data_r <= (ctl.ok && ctl.rd_en) ? rd_w[ias_pkg::DATA_W-1:0] : '0;
      fill_r <= cnt_w[ias_pkg::FILL_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.data_out   = data_r;
  assign out_ch.fill_count = fill_r;

endmodule

[test/indexed_array_stack_top_tb.sv]
// Testbench for indexed_array_stack_top: directed and random requests, with each
// result checked against an in-bench model of the array and its fill count.
// Depends on ias_pkg, ias_in_if, ias_out_if and the block itself.
module indexed_array_stack_top_tb;
  import ias_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 175;
  localparam logic [CMD_W-1:0] CMD_TOP = '1;
  localparam logic [CMD_W-1:0] CMD_BAD = CMD_W'(CMD_REMOVE + 1);

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [FILL_W-1:0] fill;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  ias_in_if  in_ch();
  ias_out_if out_ch();

  indexed_array_stack_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the array
  logic [DATA_W-1:0] stack_slots [DEPTH];
  int                stack_fill;

  outcome_t outcome_q[$];
  outcome_t head;
  int       mismatch_count;
  int       quiet_cycles;
  int       send_idle_pct;
  int       recv_stall_pct;

  function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [POS_W-1:0] pos,
                                             input logic [DATA_W-1:0] data);
    outcome_t r;
    int       i;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        if (stack_fill < DEPTH) begin
          stack_slots[stack_fill] = data;
          stack_fill++;
          r.ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          r.data = stack_slots[stack_fill];
          r.ok   = 1'b1;
        end
      end
      CMD_GET: begin
        if (pos < stack_fill) begin
          r.data = stack_slots[pos];
          r.ok   = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (stack_fill < DEPTH && pos <= stack_fill) begin
          for (i = stack_fill; i > pos; i--)
            stack_slots[i] = stack_slots[i-1];
          stack_slots[pos] = data;
          stack_fill++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos < stack_fill) begin
          r.data = stack_slots[pos];
          for (i = pos; i + 1 < stack_fill; i++)
            stack_slots[i] = stack_slots[i+1];
          stack_fill--;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.fill = stack_fill[FILL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // called and returns at a falling edge; valid stays high for the next request
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.position <= pos;
    in_ch.data_in  <= data;
    do @(posedge clk); while (!in_ch.ready);
    outcome_q.push_back(apply_command(cmd, pos, data));
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outcome_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, out_ch.data_out);
      end else begin
        head = outcome_q.pop_front();
        if (out_ch.ok !== head.ok)
          report_mismatch("ok", DATA_W'(head.ok), DATA_W'(out_ch.ok));
        if (out_ch.data_out !== head.data)
          report_mismatch("data_out", head.data, out_ch.data_out);
        if (out_ch.fill_count !== head.fill)
          report_mismatch("fill_count", DATA_W'(head.fill), DATA_W'(out_ch.fill_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
          $display("** indexed_array_stack_top: FAILED **");
          $finish;
        end
      end
    end
  end

  // rejections on an empty array, bad index on insert, unknown commands
  task automatic test_empty_array();
    send_request(CMD_POP, '0, '0);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_INSERT, 4'd1, 32'h1234_5678);
    send_request(CMD_BAD, '0, '1);
    send_request(CMD_TOP, '1, '1);
  endtask

  task automatic test_insert_get_remove();
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_PUSH, '0, '1);
    send_request(CMD_INSERT, 4'd1, 32'hA5A5_A5A5);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_GET, 4'd2, '0);
    send_request(CMD_GET, '1, '0);
    send_request(CMD_REMOVE, 4'd1, '0);
    send_request(CMD_REMOVE, 4'd2, '0);
    send_request(CMD_POP, '0, '0);
    send_request(CMD_POP, '0, '0);
  endtask

  task automatic test_full_array();
    int k;
    for (k = 0; k < DEPTH; k++)
      send_request(CMD_PUSH, '0, $urandom);
    send_request(CMD_PUSH, '0, '1);
    send_request(CMD_INSERT, '0, '1);
    send_request(CMD_GET, '1, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_INSERT, 4'(DEPTH - 1), 32'h5A5A_5A5A);
    send_request(CMD_REMOVE, 4'(DEPTH - 1), '0);
  endtask

  // bursts that lean towards growth or shrinkage so both full and empty are hit
  task automatic random_requests(input int n_items, input bit pause_midway);
    int                k;
    int                burst_left;
    int                roll;
    int                hi;
    bit                grow;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
    burst_left = 0;
    grow       = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (pause_midway && k == n_items / 2)
        wait_for_drain();
      if (burst_left == 0) begin
        grow       = ~grow;
        burst_left = $urandom_range(8, 40);
      end
      burst_left--;
      roll = $urandom_range(99);
      if (roll < 4)
        cmd = CMD_W'($urandom_range(CMD_BAD, CMD_TOP));
      else if (grow)
        cmd = (roll < 45) ? CMD_PUSH : (roll < 75) ? CMD_INSERT :
              (roll < 85) ? CMD_GET : (roll < 92) ? CMD_POP : CMD_REMOVE;
      else
        cmd = (roll < 35) ? CMD_POP : (roll < 65) ? CMD_REMOVE :
              (roll < 80) ? CMD_GET : (roll < 90) ? CMD_PUSH : CMD_INSERT;
      hi = (stack_fill < DEPTH - 1) ? stack_fill : DEPTH - 1;
      if ($urandom_range(9) == 0)
        pos = POS_W'($urandom);
      else
        pos = POS_W'($urandom_range(0, hi));
      roll = $urandom_range(15);
      data = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
      send_request(cmd, pos, data);
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_requests(PHASE_ITEMS, 1'b0);
    send_idle_pct  = 51;
    random_requests(PHASE_ITEMS, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    random_requests(PHASE_ITEMS, 1'b1);
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    random_requests(PHASE_ITEMS, 1'b0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = '0;
    in_ch.position = '0;
    in_ch.data_in  = '0;
    out_ch.ready   = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stack_fill     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_array();
    test_insert_get_remove();
    test_full_array();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** indexed_array_stack_top: PASSED **");
    else
      $display("** indexed_array_stack_top: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/ias_pkg.sv
sv/ias_in_if.sv
sv/ias_out_if.sv
sv/ias_cell.sv
sv/ias_ctrl.sv
sv/indexed_array_stack_top.sv
test/indexed_array_stack_top_tb.sv
